// ===== design/dmwbc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmwbc_pkg
// Shared constants, types and helper functions for the direct-mapped
// write-back cache.
// ----------------------------------------------------------------------------
package dmwbc_pkg;

  localparam int SET_BITS = 4;
  localparam int SETS     = 1 << SET_BITS;
  localparam int TAG_BITS = 30 - SET_BITS;
  localparam int OFF_BITS = 2;
  localparam int ENTRY_W  = TAG_BITS + SET_BITS + 32;

  localparam logic [1:0] ACT_STORE  = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_REFILL = 2'd2;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_WB   = 2'd1;
  localparam logic [1:0] KIND_REQ  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FL_RD,
    ST_FL_EM,
    ST_REQ,
    ST_PEND_RD,
    ST_PEND_EM
  } state_t;

  typedef enum logic [1:0] {
    RD_IN,
    RD_SET,
    RD_IDX,
    RD_PEND
  } rd_sel_t;

  typedef enum logic [2:0] {
    SRC_HIT,
    SRC_WB_SET,
    SRC_WB_IDX,
    SRC_REQ,
    SRC_PEND
  } src_t;

  typedef struct packed {
    logic    capture;
    rd_sel_t rd_sel;
    logic    store_wr;
    logic    refill_wr;
    logic    cnt_load;
    logic    cnt_store;
    logic    cnt_miss;
    logic    cnt_mread;
    logic    cnt_mwrite;
    logic    emit;
    src_t    src;
    logic    emit_last;
    logic    clr_dirty;
    logic    idx_clr;
    logic    idx_inc;
    logic    start_wait;
    logic    end_wait;
  } cmd_t;

  typedef struct packed {
    logic       awaiting;
    logic [1:0] action;
    logic       hit;
    logic       conflict;
    logic       any_dirty;
    logic       idx_dirty;
    logic       idx_last;
    logic       pos_last;
    logic       out_free;
  } sts_t;

  function automatic logic [31:0] load_value(input logic [31:0] word,
                                             input logic [1:0]  off,
                                             input logic [1:0]  size,
                                             input logic        sign);
    logic [7:0]  b0, b1, b2, b3;
    logic [31:0] v, m;
    logic        f;
    b0 = word[7:0];
    b1 = word[15:8];
    b2 = word[23:16];
    b3 = word[31:24];
    case (off)
      2'd1: begin
        b0 = b1;
      end
      2'd2: begin
        b0 = b2;
        b1 = b3;
      end
      2'd3: begin
        b0 = b3;
      end
      default: begin
      end
    endcase
    v = {24'd0, b0};
    m = 32'h0000_00FF;
    if (size[0]) begin
      v[15:8] = b1;
      m[15:8] = 8'hFF;
    end
    if (size[1]) begin
      v[31:16] = {b3, b2};
      m[31:16] = 16'hFFFF;
    end
    f = size[0] ? v[15] : v[7];
    if (sign && f) begin
      v = v | ~m;
    end
    return v;
  endfunction

  function automatic logic [31:0] store_merge(input logic [31:0] word,
                                              input logic [1:0]  off,
                                              input logic [1:0]  size,
                                              input logic [31:0] data);
    logic [31:0] w;
    logic [1:0]  off1;
    w    = word;
    off1 = off + 2'd1;
    w[{off, 3'b000} +: 8] = data[7:0];
    if (size[0]) begin
      w[{off1, 3'b000} +: 8] = data[15:8];
    end
    if (size[1]) begin
      w[31:16] = data[31:16];
    end
    return w;
  endfunction

endpackage

// ===== design/dmwbc_ram.sv =====
// ----------------------------------------------------------------------------
// dmwbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmwbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/dmwbc_datapath.sv =====
// ----------------------------------------------------------------------------
// dmwbc_datapath
// Line store, dirty/valid bits, refill tracking, event counters and the
// result register.
// ----------------------------------------------------------------------------
module dmwbc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_action,
  input  logic [31:0]         in_address,
  input  logic [31:0]         in_data,
  input  logic [1:0]          in_size_code,
  input  logic                in_sign_extend,
  input  dmwbc_pkg::cmd_t     cmd,
  output dmwbc_pkg::sts_t     sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic                out_last,
  output logic [31:0]         out_data_res,
  output logic [29:0]         out_mem_word_address,
  output logic [31:0]         out_miss_count,
  output logic [31:0]         out_load_count,
  output logic [31:0]         out_store_count,
  output logic [31:0]         out_mem_read_count,
  output logic [31:0]         out_mem_write_count
);

  localparam int SB = dmwbc_pkg::SET_BITS;
  localparam int TB = dmwbc_pkg::TAG_BITS;

  logic [1:0]  act_r;
  logic [31:0] addr_r, data_r;
  logic [1:0]  size_r;
  logic        sign_r;
  logic [31:0] pend_addr_r;
  logic [1:0]  pend_size_r;
  logic        pend_sign_r;
  logic        awaiting_r;
  logic [SB-1:0] pos_r, idx_r;
  logic [dmwbc_pkg::SETS-1:0] wv_r, dirty_r;
  logic        rvalid_r;

  logic [31:0] miss_r, load_r, store_r, mread_r, mwrite_r;
  logic [31:0] miss_nxt, load_nxt, store_nxt, mread_nxt, mwrite_nxt;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic        last_r;
  logic [31:0] dres_r;
  logic [29:0] wa_r;
  logic [31:0] smiss_r, sload_r, sstore_r, smread_r, smwrite_r;

  logic [SB-1:0] item_set, raddr, waddr;
  logic [TB-1:0] item_tag, pend_tag, r_tag;
  logic [SB-1:0] r_mark;
  logic [31:0]   r_word;
  logic [dmwbc_pkg::ENTRY_W-1:0] rdata, wdata;
  logic          we;
  logic [1:0]    e_kind;
  logic [31:0]   e_data;
  logic [29:0]   e_wa;

  assign item_set = addr_r[SB+1:2];
  assign item_tag = addr_r[31:SB+2];
  assign pend_tag = pend_addr_r[31:SB+2];

  always_comb begin
    case (cmd.rd_sel)
      dmwbc_pkg::RD_IN:   raddr = in_address[SB+1:2];
      dmwbc_pkg::RD_SET:  raddr = item_set;
      dmwbc_pkg::RD_IDX:  raddr = idx_r;
      dmwbc_pkg::RD_PEND: raddr = pend_addr_r[SB+1:2];
      default:            raddr = idx_r;
    endcase
  end

  assign we    = cmd.store_wr | cmd.refill_wr;
  assign waddr = cmd.store_wr ? item_set : pos_r;
  assign wdata = cmd.store_wr ?
                 {item_tag, item_set, dmwbc_pkg::store_merge(r_word, addr_r[1:0], size_r,
                                                             data_r)} :
                 {pend_tag, pos_r, data_r};

  dmwbc_ram #(
    .WIDTH (dmwbc_pkg::ENTRY_W),
    .DEPTH (dmwbc_pkg::SETS)
  ) u_lines (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign r_word = rvalid_r ? rdata[31:0] : 32'd0;
  assign r_mark = rvalid_r ? rdata[SB+31:32] : '0;
  assign r_tag  = rvalid_r ? rdata[dmwbc_pkg::ENTRY_W-1:SB+32] : '0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= in_action;
      addr_r <= in_address;
      data_r <= in_data;
      size_r <= in_size_code;
      sign_r <= in_sign_extend;
    end
    if (cmd.start_wait) begin
      pend_addr_r <= addr_r;
      pend_size_r <= size_r;
      pend_sign_r <= sign_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      pos_r      <= '0;
      idx_r      <= '0;
      wv_r       <= '0;
      dirty_r    <= '0;
      rvalid_r   <= 1'b0;
    end else begin
      rvalid_r <= wv_r[raddr];
      if (we) begin
        wv_r[waddr] <= 1'b1;
      end
      if (cmd.store_wr) begin
        dirty_r[item_set] <= 1'b1;
      end
      if (cmd.clr_dirty) begin
        dirty_r[idx_r] <= 1'b0;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + SB'(1);
      end
      if (cmd.start_wait) begin
        awaiting_r <= 1'b1;
        pos_r      <= '0;
      end else if (cmd.refill_wr) begin
        pos_r <= pos_r + SB'(1);
      end
      if (cmd.end_wait) begin
        awaiting_r <= 1'b0;
      end
    end
  end

  // counters
  assign miss_nxt   = miss_r + {31'd0, cmd.cnt_miss};
  assign load_nxt   = load_r + {31'd0, cmd.cnt_load};
  assign store_nxt  = store_r + {31'd0, cmd.cnt_store};
  assign mread_nxt  = mread_r + {31'd0, cmd.cnt_mread};
  assign mwrite_nxt = mwrite_r + {31'd0, cmd.cnt_mwrite};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_r   <= '0;
      load_r   <= '0;
      store_r  <= '0;
      mread_r  <= '0;
      mwrite_r <= '0;
    end else begin
      miss_r   <= miss_nxt;
      load_r   <= load_nxt;
      store_r  <= store_nxt;
      mread_r  <= mread_nxt;
      mwrite_r <= mwrite_nxt;
    end
  end

  always_comb begin
    case (cmd.src)
      dmwbc_pkg::SRC_HIT: begin
        e_kind = dmwbc_pkg::KIND_LOAD;
        e_data = dmwbc_pkg::load_value(r_word, addr_r[1:0], size_r, sign_r);
        e_wa   = '0;
      end
      dmwbc_pkg::SRC_WB_SET: begin
        e_kind = dmwbc_pkg::KIND_WB;
        e_data = r_word;
        e_wa   = {r_tag, item_set};
      end
      dmwbc_pkg::SRC_WB_IDX: begin
        e_kind = dmwbc_pkg::KIND_WB;
        e_data = r_word;
        e_wa   = {r_tag, idx_r};
      end
      dmwbc_pkg::SRC_REQ: begin
        e_kind = dmwbc_pkg::KIND_REQ;
        e_data = '0;
        e_wa   = {item_tag, {SB{1'b0}}};
      end
      dmwbc_pkg::SRC_PEND: begin
        e_kind = dmwbc_pkg::KIND_LOAD;
        e_data = dmwbc_pkg::load_value(r_word, pend_addr_r[1:0], pend_size_r, pend_sign_r);
        e_wa   = '0;
      end
      default: begin
        e_kind = dmwbc_pkg::KIND_LOAD;
        e_data = '0;
        e_wa   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r    <= e_kind;
      last_r    <= cmd.emit_last;
      dres_r    <= e_data;
      wa_r      <= e_wa;
      smiss_r   <= miss_nxt;
      sload_r   <= load_nxt;
      sstore_r  <= store_nxt;
      smread_r  <= mread_nxt;
      smwrite_r <= mwrite_nxt;
    end
  end

  assign sts.awaiting  = awaiting_r;
  assign sts.action    = act_r;
  assign sts.hit       = (r_tag == item_tag) && (r_mark == item_set);
  assign sts.conflict  = dirty_r[item_set] && (r_tag != item_tag);
  assign sts.any_dirty = |dirty_r;
  assign sts.idx_dirty = dirty_r[idx_r];
  assign sts.idx_last  = &idx_r;
  assign sts.pos_last  = &pos_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid            = out_valid_r;
  assign out_kind             = kind_r;
  assign out_last             = last_r;
  assign out_data_res         = dres_r;
  assign out_mem_word_address = wa_r;
  assign out_miss_count       = smiss_r;
  assign out_load_count       = sload_r;
  assign out_store_count      = sstore_r;
  assign out_mem_read_count   = smread_r;
  assign out_mem_write_count  = smwrite_r;

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result issued over an unaccepted one");
  a_clean_wait: assert property (@(posedge clk) disable iff (!rst_n)
    awaiting_r |-> (dirty_r == '0))
    else $error("dirty line while awaiting refill");
  a_req_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.src == dmwbc_pkg::SRC_REQ) |=> awaiting_r)
    else $error("refill request without refill wait");
`endif

endmodule

// ===== design/dmwbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmwbc_ctrl
// Controller: lookup, store, flush walk, refill request and refill release.
// ----------------------------------------------------------------------------
module dmwbc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dmwbc_pkg::sts_t     sts,
  output dmwbc_pkg::cmd_t     cmd
);

  dmwbc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmwbc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = dmwbc_pkg::RD_IDX;
    cmd.src    = dmwbc_pkg::SRC_HIT;
    in_stall   = 1'b1;
    case (state_r)
      dmwbc_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.rd_sel = dmwbc_pkg::RD_IN;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = dmwbc_pkg::ST_LOOKUP;
        end
      end
      dmwbc_pkg::ST_LOOKUP: begin
        cmd.rd_sel = dmwbc_pkg::RD_SET;
        if (sts.out_free) begin
          state_nxt = dmwbc_pkg::ST_IDLE;
          if (sts.awaiting) begin
            if (sts.action == dmwbc_pkg::ACT_REFILL) begin
              cmd.refill_wr = 1'b1;
              if (sts.pos_last) begin
                state_nxt = dmwbc_pkg::ST_PEND_RD;
              end
            end
          end else if (sts.action == dmwbc_pkg::ACT_STORE) begin
            cmd.cnt_store = 1'b1;
            cmd.store_wr  = 1'b1;
            if (sts.conflict) begin
              cmd.cnt_miss   = 1'b1;
              cmd.cnt_mwrite = 1'b1;
              cmd.emit       = 1'b1;
              cmd.emit_last  = 1'b1;
              cmd.src        = dmwbc_pkg::SRC_WB_SET;
            end
          end else if (sts.action == dmwbc_pkg::ACT_LOAD) begin
            cmd.cnt_load = 1'b1;
            if (sts.hit) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.src       = dmwbc_pkg::SRC_HIT;
            end else begin
              cmd.cnt_mread  = 1'b1;
              cmd.cnt_miss   = 1'b1;
              cmd.cnt_mwrite = sts.any_dirty;
              cmd.idx_clr    = 1'b1;
              state_nxt      = dmwbc_pkg::ST_FL_RD;
            end
          end
        end
      end
      dmwbc_pkg::ST_FL_RD: begin
        if (sts.idx_dirty) begin
          state_nxt = dmwbc_pkg::ST_FL_EM;
        end else if (sts.idx_last) begin
          state_nxt = dmwbc_pkg::ST_REQ;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      dmwbc_pkg::ST_FL_EM: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.src       = dmwbc_pkg::SRC_WB_IDX;
          cmd.clr_dirty = 1'b1;
          if (sts.idx_last) begin
            state_nxt = dmwbc_pkg::ST_REQ;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = dmwbc_pkg::ST_FL_RD;
          end
        end
      end
      dmwbc_pkg::ST_REQ: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_last  = 1'b1;
          cmd.src        = dmwbc_pkg::SRC_REQ;
          cmd.start_wait = 1'b1;
          state_nxt      = dmwbc_pkg::ST_IDLE;
        end
      end
      dmwbc_pkg::ST_PEND_RD: begin
        cmd.rd_sel = dmwbc_pkg::RD_PEND;
        state_nxt  = dmwbc_pkg::ST_PEND_EM;
      end
      dmwbc_pkg::ST_PEND_EM: begin
        cmd.rd_sel = dmwbc_pkg::RD_PEND;
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.src       = dmwbc_pkg::SRC_PEND;
          cmd.end_wait  = 1'b1;
          state_nxt     = dmwbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dmwbc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/direct_mapped_writeback_cache.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache
// Direct-mapped write-back cache of one-word lines with flush-on-miss and
// whole-region refill.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | action, address, data, size_code, sign_extend
//  out     | out_valid/out_stall| kind, last, data_res, mem_word_address, counts
//
// One item at a time: stores, hits, ignored items and refill words pass idle
// and lookup; the final refill word also passes pending read and emit. A load
// miss walks all SETS lines, writing back dirty ones, then issues the request.
// The line RAM has one read port. Reset is synchronous; dirty and valid bits
// clear at once, so no clearing pass. A stalled output holds the controller.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_address,
  input  logic [31:0] in_data,
  input  logic [1:0]  in_size_code,
  input  logic        in_sign_extend,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic        out_last,
  output logic [31:0] out_data_res,
  output logic [29:0] out_mem_word_address,
  output logic [31:0] out_miss_count,
  output logic [31:0] out_load_count,
  output logic [31:0] out_store_count,
  output logic [31:0] out_mem_read_count,
  output logic [31:0] out_mem_write_count
);

  dmwbc_pkg::cmd_t cmd;
  dmwbc_pkg::sts_t sts;

  dmwbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dmwbc_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_action            (in_action),
    .in_address           (in_address),
    .in_data              (in_data),
    .in_size_code         (in_size_code),
    .in_sign_extend       (in_sign_extend),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_last             (out_last),
    .out_data_res         (out_data_res),
    .out_mem_word_address (out_mem_word_address),
    .out_miss_count       (out_miss_count),
    .out_load_count       (out_load_count),
    .out_store_count      (out_store_count),
    .out_mem_read_count   (out_mem_read_count),
    .out_mem_write_count  (out_mem_write_count)
  );

endmodule
